### rtl/text_attribute_colour_converter_defines.svh
// Assertion macros shared by the converter RTL.
`ifndef TEXT_ATTRIBUTE_COLOUR_CONVERTER_DEFINES_SVH
`define TEXT_ATTRIBUTE_COLOUR_CONVERTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TACC_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tacc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TACC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tacc: next-cycle check failed");

`endif

### rtl/tacc_pkg.sv
package tacc_pkg;

    localparam int FieldW = 14;
    localparam int DistW  = 10;
    localparam int NumPal = 16;
    localparam int IdxW   = 4;
    localparam int GroupN = 4;

    localparam logic [FieldW-1:0] TAG_BASE        = 14'h0040;
    localparam logic [FieldW-1:0] TAG_DEFAULT     = 14'h0050;
    localparam logic [FieldW-1:0] TAG_TRANSPARENT = 14'h0060;
    localparam logic [FieldW-1:0] ALPHA_LIMIT     = 14'h0fff;

    localparam logic [5:0] ANSI_DEFAULT     = 6'd16;
    localparam logic [5:0] ANSI_TRANSPARENT = 6'd32;
    localparam logic [3:0] ANSI_LIGHTGREY   = 4'd7;
    localparam logic [3:0] ANSI_BLACK       = 4'd0;

    localparam logic [15:0] ARGB_TRANSPARENT = 16'h0fff;

    localparam logic [0:NumPal-1][15:0] PAL_ARGB16 = '{
        16'hf000, 16'hf00a, 16'hf0a0, 16'hf0aa, 16'hfa00, 16'hfa0a, 16'hfa50, 16'hfaaa,
        16'hf555, 16'hf55f, 16'hf5f5, 16'hf5ff, 16'hff55, 16'hff5f, 16'hfff5, 16'hffff
    };

    localparam logic [0:NumPal-1][FieldW-1:0] PAL_ARGB14 = '{
        14'h3800, 14'h3805, 14'h3850, 14'h3855, 14'h3d00, 14'h3d05, 14'h3d28, 14'h3d55,
        14'h3aaa, 14'h3aaf, 14'h3afa, 14'h3aff, 14'h3faa, 14'h3faf, 14'h3ffa, 14'h3fff
    };

    typedef struct packed {
        logic [DistW-1:0] score;
        logic [IdxW-1:0]  idx;
    } t_cand;

    typedef struct packed {
        logic [FieldW-1:0]            fg;
        logic [FieldW-1:0]            bg;
        logic [NumPal-1:0][DistW-1:0] fg_dist;
        logic [NumPal-1:0][DistW-1:0] bg_dist;
    } t_s1;

    typedef struct packed {
        logic [FieldW-1:0]       fg;
        logic [FieldW-1:0]       bg;
        logic [GroupN-1:0][DistW+IdxW-1:0] fg_cand;
        logic [GroupN-1:0][DistW+IdxW-1:0] bg_cand;
    } t_s2;

    // First member sits in the top bits, so the last one lands at bit 0 of tdata.
    typedef struct packed {
        logic [15:0] bg_argb;
        logic [15:0] fg_argb;
        logic [23:0] bg_rgb24;
        logic [23:0] fg_rgb24;
        logic [11:0] bg_rgb12;
        logic [11:0] fg_rgb12;
        logic [7:0]  ansi_pair;
        logic [5:0]  bg_ansi;
        logic [5:0]  fg_ansi;
    } t_result;

    function automatic logic [7:0] f_sq_diff(input logic [3:0] a, input logic [3:0] b);
        logic [3:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return 8'(d) * 8'(d);
    endfunction

    // Squared RGB distance between a colour field and one palette entry.
    function automatic logic [DistW-1:0] f_dist(input logic [FieldW-1:0] v,
                                                input logic [IdxW-1:0]   i);
        logic [FieldW-1:0] p;
        p = PAL_ARGB14[i];
        return DistW'(f_sq_diff(p[10:7], v[10:7]))
             + DistW'(f_sq_diff(p[6:3], v[6:3]))
             + DistW'(f_sq_diff({p[2:0], 1'b0}, {v[2:0], 1'b0}));
    endfunction

    // The right-hand candidate wins only on a strictly smaller distance.
    function automatic t_cand f_pick(input t_cand a, input t_cand b);
        return (b.score < a.score) ? b : a;
    endfunction

    function automatic logic f_is_tag(input logic [FieldW-1:0] v);
        return (v >= TAG_BASE) && (v < TAG_DEFAULT);
    endfunction

    function automatic logic [5:0] f_ansi(input logic [FieldW-1:0] v,
                                          input logic [IdxW-1:0]   best);
        logic [5:0] r;
        if (f_is_tag(v)) begin
            r = {2'b00, v[3:0]};
        end else if (v == TAG_DEFAULT) begin
            r = ANSI_DEFAULT;
        end else if ((v == TAG_TRANSPARENT) || (v < ALPHA_LIMIT)) begin
            r = ANSI_TRANSPARENT;
        end else begin
            r = {2'b00, best};
        end
        return r;
    endfunction

    function automatic logic [15:0] f_argb(input logic [FieldW-1:0] v, input logic is_fg);
        logic [15:0] r;
        if (f_is_tag(v)) begin
            r = PAL_ARGB16[v[3:0]];
        end else if (v == TAG_DEFAULT) begin
            r = PAL_ARGB16[is_fg ? ANSI_LIGHTGREY : ANSI_BLACK];
        end else if (v == TAG_TRANSPARENT) begin
            r = ARGB_TRANSPARENT;
        end else begin
            // The alpha nibble's low bit repeats the top bit of red.
            r = {v[13:10], v[10:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [11:0] f_rgb12(input logic [FieldW-1:0] v, input logic is_fg);
        logic [15:0] p;
        logic [11:0] r;
        if (f_is_tag(v)) begin
            p = PAL_ARGB16[v[3:0]];
            r = p[11:0];
        end else if ((v == TAG_DEFAULT) || (v == TAG_TRANSPARENT)) begin
            p = PAL_ARGB16[is_fg ? ANSI_LIGHTGREY : ANSI_BLACK];
            r = p[11:0];
        end else begin
            r = {v[10:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [23:0] f_rgb24(input logic [11:0] c);
        return {c[11:8], c[11:8], c[7:4], c[7:4], c[3:0], c[3:0]};
    endfunction

    function automatic logic [3:0] f_pair_nibble(input logic [5:0] idx, input logic [3:0] subst);
        return ((idx == ANSI_DEFAULT) || (idx == ANSI_TRANSPARENT)) ? subst : idx[3:0];
    endfunction

endpackage

### rtl/text_attribute_colour_converter.sv
// Converts one 32-bit text-cell attribute per clock into the nearest ANSI
// colour indices, a packed ANSI colour byte and RGB12, RGB24 and ARGB16
// expansions of its foreground (bits 17:4) and background (bits 31:18); the
// style flags in bits 3:0 are ignored. A request is taken in every cycle that
// the output side keeps up, and its result passes through the stage registers
// r_s1, r_s2 and r_s3 to the output: the first stage works out the squared
// distance to all sixteen palette entries for both colours, the second
// narrows each set of sixteen to four candidates, and the third picks the
// winner, lower index first on a tie, and formats the result into the output
// register. Stalls ripple back stage by stage, so a bubble anywhere is filled
// by the next request.
`include "text_attribute_colour_converter_defines.svh"

module text_attribute_colour_converter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [31:0]  i_s_tdata,   // attribute[31:0]
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // fg_ansi[5:0], bg_ansi[11:6], ansi_pair[19:12], fg_rgb12[31:20],
    // bg_rgb12[43:32], fg_rgb24[67:44], bg_rgb24[91:68], fg_argb[107:92],
    // bg_argb[123:108], zero padding[127:124]
    output logic [127:0] o_m_tdata
);
    import tacc_pkg::*;

    logic    r_s1_valid, r_s2_valid, r_s3_valid;
    logic    n_s1_valid, n_s2_valid, n_s3_valid;
    t_s1     r_s1, n_s1;
    t_s2     r_s2, n_s2;
    t_result r_s3, n_s3;
    logic    w_s1_en, w_s2_en, w_s3_en;
    logic    w_fg_indexed, w_bg_subst, w_fg_clear;

    assign w_s3_en    = !r_s3_valid || i_m_tready;
    assign w_s2_en    = !r_s2_valid || w_s3_en;
    assign w_s1_en    = !r_s1_valid || w_s2_en;
    assign o_s_tready = w_s1_en;

    assign n_s1_valid = i_s_tvalid;
    assign n_s2_valid = r_s1_valid;
    assign n_s3_valid = r_s2_valid;

    // Stage one: distances to every palette entry.
    always_comb begin
        n_s1.fg = i_s_tdata[17:4];
        n_s1.bg = i_s_tdata[31:18];
        for (int i = 0; i < NumPal; i++) begin
            n_s1.fg_dist[i] = f_dist(i_s_tdata[17:4], IdxW'(i));
            n_s1.bg_dist[i] = f_dist(i_s_tdata[31:18], IdxW'(i));
        end
    end

    // Stage two: best of each group of four entries.
    always_comb begin
        t_cand fc [NumPal];
        t_cand bc [NumPal];
        t_cand f01, f23, b01, b23;
        for (int i = 0; i < NumPal; i++) begin
            fc[i] = '{score: r_s1.fg_dist[i], idx: IdxW'(i)};
            bc[i] = '{score: r_s1.bg_dist[i], idx: IdxW'(i)};
        end
        n_s2.fg = r_s1.fg;
        n_s2.bg = r_s1.bg;
        for (int g = 0; g < GroupN; g++) begin
            f01 = f_pick(fc[GroupN*g],     fc[GroupN*g + 1]);
            f23 = f_pick(fc[GroupN*g + 2], fc[GroupN*g + 3]);
            b01 = f_pick(bc[GroupN*g],     bc[GroupN*g + 1]);
            b23 = f_pick(bc[GroupN*g + 2], bc[GroupN*g + 3]);
            n_s2.fg_cand[g] = f_pick(f01, f23);
            n_s2.bg_cand[g] = f_pick(b01, b23);
        end
    end

    // Stage three: overall winner and output formatting.
    always_comb begin
        t_cand       fbest, bbest;
        logic [11:0] f12, b12;
        fbest = f_pick(f_pick(t_cand'(r_s2.fg_cand[0]), t_cand'(r_s2.fg_cand[1])),
                       f_pick(t_cand'(r_s2.fg_cand[2]), t_cand'(r_s2.fg_cand[3])));
        bbest = f_pick(f_pick(t_cand'(r_s2.bg_cand[0]), t_cand'(r_s2.bg_cand[1])),
                       f_pick(t_cand'(r_s2.bg_cand[2]), t_cand'(r_s2.bg_cand[3])));
        f12 = f_rgb12(r_s2.fg, 1'b1);
        b12 = f_rgb12(r_s2.bg, 1'b0);
        n_s3.fg_ansi   = f_ansi(r_s2.fg, fbest.idx);
        n_s3.bg_ansi   = f_ansi(r_s2.bg, bbest.idx);
        n_s3.ansi_pair = {f_pair_nibble(n_s3.bg_ansi, ANSI_BLACK),
                          f_pair_nibble(n_s3.fg_ansi, ANSI_LIGHTGREY)};
        n_s3.fg_rgb12  = f12;
        n_s3.bg_rgb12  = b12;
        n_s3.fg_rgb24  = f_rgb24(f12);
        n_s3.bg_rgb24  = f_rgb24(b12);
        n_s3.fg_argb   = f_argb(r_s2.fg, 1'b1);
        n_s3.bg_argb   = f_argb(r_s2.bg, 1'b0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (w_s1_en) begin
                r_s1_valid <= n_s1_valid;
            end
            if (w_s2_en) begin
                r_s2_valid <= n_s2_valid;
            end
            if (w_s3_en) begin
                r_s3_valid <= n_s3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_en) begin
            r_s1 <= n_s1;
        end
        if (w_s2_en) begin
            r_s2 <= n_s2;
        end
        if (w_s3_en) begin
            r_s3 <= n_s3;
        end
    end

    assign o_m_tvalid = r_s3_valid;
    assign o_m_tdata  = {4'b0000, r_s3};

    assign w_fg_indexed = r_s3_valid && (r_s3.fg_ansi < ANSI_DEFAULT);
    assign w_bg_subst   = r_s3_valid && ((r_s3.bg_ansi == ANSI_DEFAULT) ||
                                         (r_s3.bg_ansi == ANSI_TRANSPARENT));
    assign w_fg_clear   = r_s3_valid && (r_s3.fg_ansi == ANSI_TRANSPARENT);

    `TACC_ASSERT_NOW(a_fg_pair_match, w_fg_indexed, r_s3.ansi_pair[3:0] == r_s3.fg_ansi[3:0])
    `TACC_ASSERT_NOW(a_bg_pair_subst, w_bg_subst, r_s3.ansi_pair[7:4] == ANSI_BLACK)
    `TACC_ASSERT_NOW(a_fg_transp_alpha, w_fg_clear, r_s3.fg_argb[15:14] == 2'b00)
    `TACC_ASSERT_NEXT(a_s2_stall_holds, r_s2_valid && !w_s3_en, r_s2_valid)

endmodule
